// ----- rtl/sha256_pkg.sv -----
// Shared constants, types and the rotate function for the SHA-256 hash engine.
package sha256_pkg;

    localparam int unsigned RoundCount = 64;

    localparam logic [31:0] INIT_VECTOR [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_POSITION = 6'd56;

    // Control from the byte packer to the round unit
    typedef struct packed {
        logic start;
    } comp_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } comp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/sha256_round_unit.sv -----
// SHA-256 compression: one round per cycle over a rolling 16-word schedule.
module sha256_round_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha256_pkg::comp_req_t  req,
    output sha256_pkg::comp_stat_t stat,
    input  logic [31:0]            block_words [16],
    input  logic [31:0]            chain_in [8],
    output logic [31:0]            chain_out [8]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD
    } state_t;

    state_t      state_reg;
    logic [5:0]  round_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] out_reg [8];
    logic        done_reg;

    logic [31:0] s0, s1, w_new, big0, big1, choose, major, t1, t2;

    // Round datapath and next schedule word
    always_comb begin
        s0     = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
                 ^ (w_reg[1] >> 3);
        s1     = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
                 ^ (w_reg[14] >> 10);
        w_new  = s1 + w_reg[9] + s0 + w_reg[0];
        big1   = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
                 ^ sha256_pkg::rotr(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big1 + choose + sha256_pkg::ROUND_K[round_reg] + w_reg[0];
        big0   = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
                 ^ sha256_pkg::rotr(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big0 + major;
    end

    // Sequence the 64 rounds, then add into the chain value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        w_reg     <= block_words;
                        v_reg     <= chain_in;
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(sha256_pkg::RoundCount - 1)) state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) out_reg[i] <= chain_in[i] + v_reg[i];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign stat.busy = (state_reg != ST_IDLE) || done_reg;
    assign stat.done = done_reg;
    assign chain_out = out_reg;

endmodule

// ----- rtl/sha256_hash_engine_core.sv -----
// Top level of the streaming SHA-256 hash engine.
// Message words enter on s_ (valid_bytes bytes from the top, end_of_message on the last);
// eight digest words leave on m_, index 0 first. The engine takes a word while idle, packs
// one byte per cycle into a 64-byte block (pausing while a full block is compressed) and
// then closes the word before it takes the next. Each full block goes to a round unit that
// runs one round per cycle; from hand-over to result no input is taken. End of message adds
// padding one byte per cycle (up to 72 bytes, with a step that writes no byte on reaching
// the length field), one or two compressions, then the eight digest transfers. The chain
// value returns to the initial vector afterwards.
module sha256_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_digest_index,
    output logic        m_last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] word_reg;
    logic [2:0]  left_reg;
    logic        eom_reg;
    logic [31:0] block_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bytes_reg;
    logic [63:0] bitlen_reg;
    logic [3:0]  pad_reg;   // 0: 0x80, 1: zero fill, 2..9: length bytes
    logic [31:0] chain_reg [8];
    logic [2:0]  out_idx_reg;
    logic        m_valid_reg;
    logic        after_pad_reg;

    sha256_pkg::comp_req_t  req;
    sha256_pkg::comp_stat_t stat;
    logic [31:0]            comp_out [8];
    logic [7:0]             pad_byte;
    logic [7:0]             cur_byte;
    logic [31:0]            packed_word;

    sha256_round_unit u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .stat        (stat),
        .block_words (block_reg),
        .chain_in    (chain_reg),
        .chain_out   (comp_out)
    );

    // Select the padding byte for this step
    always_comb begin
        case (pad_reg)
            4'd0:    pad_byte = sha256_pkg::PAD_BYTE;
            4'd1:    pad_byte = 8'h00;
            default: pad_byte = bitlen_reg[8*(3'd7 - 3'(pad_reg - 4'd2)) +: 8];
        endcase
        cur_byte = (state_reg == ST_PAD) ? pad_byte : word_reg[31:24];
        // Clear the word on its first byte, then merge the byte in place
        packed_word = (fill_reg[1:0] == 2'd0) ? 32'd0 : block_reg[fill_reg[5:2]];
        packed_word[8*(3 - fill_reg[1:0]) +: 8] = cur_byte;
    end

    assign req.start = (state_reg == ST_COMP) && !stat.busy && !after_pad_reg;
    assign s_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            pad_reg       <= '0;
            m_valid_reg   <= 1'b0;
            out_idx_reg   <= '0;
            after_pad_reg <= 1'b0;
            chain_reg     <= sha256_pkg::INIT_VECTOR;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        word_reg  <= s_data_word;
                        left_reg  <= (s_valid_bytes > 3'd4) ? 3'd4 : s_valid_bytes;
                        eom_reg   <= s_end_of_message;
                        pad_reg   <= '0;
                        state_reg <= ST_DATA;
                    end
                end
                // Push one message byte per cycle until the word is used up or the block is full
                ST_DATA: begin
                    if (left_reg == 3'd0) begin
                        if (eom_reg) begin
                            bitlen_reg <= {bytes_reg[60:0], 3'b000};
                            pad_reg    <= '0;
                            state_reg  <= ST_PAD;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        block_reg[fill_reg[5:2]] <= packed_word;
                        word_reg  <= {word_reg[23:0], 8'h00};
                        left_reg  <= left_reg - 3'd1;
                        bytes_reg <= bytes_reg + 64'd1;
                        fill_reg  <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            after_pad_reg <= 1'b0;
                            state_reg     <= ST_COMP;
                        end
                    end
                end
                // Push padding: 0x80, zeros up to byte 56, then the length
                ST_PAD: begin
                    if (pad_reg == 4'd1 && fill_reg == sha256_pkg::LEN_POSITION) begin
                        pad_reg <= 4'd2;
                    end else begin
                        block_reg[fill_reg[5:2]] <= packed_word;
                        fill_reg <= fill_reg + 6'd1;
                        if (pad_reg != 4'd1) pad_reg <= pad_reg + 4'd1;
                        if (fill_reg == 6'd63) begin
                            after_pad_reg <= 1'b0;
                            state_reg     <= ST_COMP;
                        end
                    end
                end
                // Wait for the round unit, then take its result
                ST_COMP: begin
                    if (req.start) after_pad_reg <= 1'b1;
                    if (stat.done) begin
                        chain_reg     <= comp_out;
                        after_pad_reg <= 1'b0;
                        if (pad_reg == 4'd10) begin
                            out_idx_reg <= '0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else if (pad_reg != 4'd0) begin
                            state_reg <= ST_PAD;
                        end else begin
                            state_reg <= ST_DATA;
                        end
                    end
                end
                // Emit the digest, then restore the initial vector
                ST_OUT: begin
                    if (m_ready) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            m_valid_reg <= 1'b0;
                            chain_reg   <= sha256_pkg::INIT_VECTOR;
                            fill_reg    <= '0;
                            bytes_reg   <= '0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_digest_word  = chain_reg[out_idx_reg];
    assign m_digest_index = out_idx_reg;
    assign m_last_word    = (out_idx_reg == 3'd7);

    // Output and input never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("input ready while digest pending");

    // Digest indices advance by one per transfer
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=> (m_digest_index == $past(m_digest_index) + 3'd1))
        else $error("digest index skipped");

    // A block is only handed over when the fill pointer wrapped
    a_start_full: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> fill_reg == 6'd0) else $error("partial block compressed");

endmodule
